### sv/wws_pkg.sv
// Shared types, constants and helpers for the Wiener weight solver.
package wws_pkg;

    localparam int NUM_TAPS = 8;
    localparam int ROW_ENT  = NUM_TAPS + 1;
    localparam int ACC_W    = 48;
    localparam int W_W      = 32;
    localparam logic [3:0] B_COL = 4'd8;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [ROW_ENT-1:0][ACC_W-1:0] t_row;

    typedef struct packed {
        logic signed [15:0] sample0;
        logic signed [15:0] sample1;
        logic signed [15:0] sample2;
        logic signed [15:0] sample3;
        logic signed [15:0] sample4;
        logic signed [15:0] sample5;
        logic signed [15:0] sample6;
        logic signed [15:0] sample7;
        logic signed [15:0] desired;
        logic               last_row;
    } t_request;

    typedef struct packed {
        logic [2:0]         weight_index;
        logic signed [31:0] weight;
        logic               singular;
        logic               last_weight;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [47:0] den;
        logic        frac16;
        logic [32:0] lim;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_ACC, S_PV_RD, S_PV_CMP, S_PV_CHK,
        S_SW_RDP, S_SW_RDK, S_SW_WRP, S_SW_WRK,
        S_EL_RD, S_EL_LD, S_EL_DIV, S_EL_COL, S_EL_WR,
        S_MUL0, S_MUL1, S_MUL_UPD,
        S_BS_RD, S_BS_LD, S_BS_COL, S_BS_DIV, S_BS_WAIT,
        S_OUT
    } t_state;

    function automatic logic [47:0] sat48(input logic signed [65:0] v);
        if (v[65:47] == {19{v[47]}}) return v[47:0];
        else if (v[65]) return {1'b1, 47'b0};
        else return {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic [63:0] sat64(input logic signed [65:0] v);
        if (v[65:63] == {3{v[63]}}) return v[63:0];
        else if (v[65]) return {1'b1, 63'b0};
        else return {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic [47:0] mag48(input logic [47:0] a);
        return a[47] ? 48'(-a) : a;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] a);
        return a[63] ? 64'(-a) : a;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] a);
        return a[31] ? 32'(-a) : a;
    endfunction

endpackage

### sv/wiener_weight_solver_top.sv
// Wiener weight solver: correlation accumulation and Gaussian-elimination solve.
// A non-last row updates the correlation rows in S_ACC (one correlation row per cycle), then returns to idle.
// A last row adds the solve: pivot scans, a divide per eliminated row, the multiply-updates
// and a divide per weight; weights then leave one per cycle.
// Synchronous active-low reset clears control, the row valid bits and active_taps to 8.
// The receiver cannot stall: each weight is on o_res for one cycle with o_valid.
module wiener_weight_solver_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  wws_pkg::t_request i_req,
    output logic              o_valid,
    output wws_pkg::t_result  o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import wws_pkg::*;

    t_state r_state, n_state;

    logic [3:0]         r_active_taps;
    logic signed [15:0] r_x [NUM_TAPS];
    logic signed [15:0] r_d;
    logic               r_last;
    logic [3:0]         r_cnt, r_n, r_k, r_r, r_c;
    logic [2:0]         r_p;
    logic [47:0]        r_pmag;
    logic               r_sing;
    logic               r_bs;

    t_row               r_mem [NUM_TAPS];
    logic [NUM_TAPS-1:0] r_vld;
    t_row               r_rdata;
    logic               r_rvld;
    t_row               rowdata;

    t_row               r_krow, r_wrow;
    logic signed [31:0] r_w [NUM_TAPS];
    logic [31:0]        r_f;
    logic               r_fneg;
    logic               r_bneg;
    logic [31:0]        r_mx;
    logic [47:0]        r_my;
    logic               r_mneg;
    logic               r_msh16;
    logic [79:0]        r_prod;
    logic signed [63:0] r_s;

    logic [2:0]  rd_addr, mem_wa;
    logic        mem_we;
    t_row        mem_wd;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic [3:0]  n_taps;
    t_row        acc_row;
    logic [15:0] mul_a;
    logic [63:0] mul_p;
    logic [79:0] pshift;
    logic [62:0] pm;
    logic signed [65:0] pv;
    logic [47:0] upd_a;
    logic [63:0] upd_s;
    logic        bs_neg;
    logic [31:0] wval;
    logic        cfg_wr;

    wws_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_active_taps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_taps <= 4'd8;
        end else if (cfg_wr && !paddr[2]) begin
            r_active_taps <= pwdata[3:0];
        end
    end

    always_comb begin
        if (r_active_taps == 4'd0) n_taps = 4'd1;
        else if (r_active_taps > 4'(NUM_TAPS)) n_taps = 4'(NUM_TAPS);
        else n_taps = r_active_taps;
    end

    // row memory
    assign rowdata = r_rvld ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[rd_addr];
            if (r_state == S_OUT && r_c == r_n - 4'd1) r_vld <= '0;
            else if (mem_we) r_vld[mem_wa] <= 1'b1;
        end
    end

    // correlation row update
    always_comb begin
        logic signed [15:0] xi;
        logic signed [31:0] prod;
        xi = r_x[3'(r_cnt - 4'd1)];
        acc_row = rowdata;
        for (int j = 0; j < NUM_TAPS; j++) begin
            prod = xi * r_x[j];
            acc_row[j] = sat48(66'($signed(rowdata[j])) + 66'(prod));
        end
        prod = xi * r_d;
        acc_row[B_COL] = sat48(66'($signed(rowdata[B_COL])) + 66'(prod));
    end

    // shared multiplier and update arithmetic
    assign mul_a = (r_state == S_MUL1) ? r_mx[31:16] : r_mx[15:0];
    assign mul_p = mul_a * r_my;

    always_comb begin
        pshift = r_msh16 ? (r_prod >> 16) : (r_prod >> 30);
        pm     = (pshift > {17'd0, 1'b1, 62'd0}) ? {1'b1, 62'd0} : pshift[62:0];
        pv     = r_mneg ? -$signed({3'b0, pm}) : $signed({3'b0, pm});
        upd_a  = sat48(66'($signed(r_wrow[r_c])) - pv);
        upd_s  = sat64(66'(r_s) - pv);
        bs_neg = r_s[63] ^ r_wrow[r_k][47];
        if (r_bneg) wval = div_rsp.quot[31] ? 32'h8000_0000 : 32'(-div_rsp.quot[31:0]);
        else wval = div_rsp.quot[31:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_ACC;
            S_ACC:     if (r_cnt == 4'd8) n_state = r_last ? S_PV_RD : S_IDLE;
            S_PV_RD:   n_state = S_PV_CMP;
            S_PV_CMP:  n_state = (r_r == r_n - 4'd1) ? S_PV_CHK : S_PV_RD;
            S_PV_CHK:  n_state = (r_pmag == '0) ? S_OUT : S_SW_RDP;
            S_SW_RDP:  n_state = S_SW_RDK;
            S_SW_RDK:  n_state = S_SW_WRP;
            S_SW_WRP:  n_state = S_SW_WRK;
            S_SW_WRK:  n_state = S_EL_RD;
            S_EL_RD: begin
                if (r_r == r_n) n_state = (r_k == r_n - 4'd1) ? S_BS_RD : S_PV_RD;
                else n_state = S_EL_LD;
            end
            S_EL_LD:   n_state = (rowdata[r_k] == '0) ? S_EL_RD : S_EL_DIV;
            S_EL_DIV:  if (div_rsp.done) n_state = S_EL_COL;
            S_EL_COL:  n_state = S_MUL0;
            S_EL_WR:   n_state = S_EL_RD;
            S_MUL0:    n_state = S_MUL1;
            S_MUL1:    n_state = S_MUL_UPD;
            S_MUL_UPD: begin
                if (r_bs) n_state = (r_c + 4'd1 == r_n) ? S_BS_DIV : S_BS_COL;
                else n_state = (r_c == B_COL) ? S_EL_WR : S_EL_COL;
            end
            S_BS_RD:   n_state = S_BS_LD;
            S_BS_LD:   n_state = (r_k + 4'd1 == r_n) ? S_BS_DIV : S_BS_COL;
            S_BS_COL:  n_state = S_MUL0;
            S_BS_DIV:  n_state = S_BS_WAIT;
            S_BS_WAIT: if (div_rsp.done) n_state = (r_k == 4'd0) ? S_OUT : S_BS_RD;
            S_OUT:     if (r_c == r_n - 4'd1) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and memory / divider control
    always_comb begin
        busy    = (r_state != S_IDLE);
        rd_addr = '0;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = acc_row;
        div_req = '0;
        o_valid = 1'b0;
        o_res.weight_index = r_c[2:0];
        o_res.weight       = r_sing ? 32'sd0 : r_w[r_c[2:0]];
        o_res.singular     = r_sing;
        o_res.last_weight  = (r_c == r_n - 4'd1);
        unique case (r_state)
            S_ACC: begin
                rd_addr = r_cnt[2:0];
                if (r_cnt != 4'd0) begin
                    mem_we = 1'b1;
                    mem_wa = 3'(r_cnt - 4'd1);
                end
            end
            S_PV_RD:  rd_addr = r_r[2:0];
            S_SW_RDP: rd_addr = r_p;
            S_SW_RDK: rd_addr = r_k[2:0];
            S_SW_WRP: begin
                mem_we = 1'b1;
                mem_wa = r_p;
                mem_wd = rowdata;
            end
            S_SW_WRK: begin
                mem_we = 1'b1;
                mem_wa = r_k[2:0];
                mem_wd = r_krow;
            end
            S_EL_RD:  rd_addr = r_r[2:0];
            S_EL_LD: begin
                div_req.start  = (rowdata[r_k] != '0);
                div_req.num    = {16'd0, mag48(rowdata[r_k])};
                div_req.den    = mag48(r_krow[r_k]);
                div_req.frac16 = 1'b0;
                div_req.lim    = 33'h0_4000_0000;
            end
            S_EL_WR: begin
                mem_we = 1'b1;
                mem_wa = r_r[2:0];
                mem_wd = r_wrow;
                mem_wd[r_k] = '0;
            end
            S_BS_RD:  rd_addr = r_k[2:0];
            S_BS_DIV: begin
                div_req.start  = 1'b1;
                div_req.num    = mag64(r_s);
                div_req.den    = mag48(r_wrow[r_k]);
                div_req.frac16 = 1'b1;
                div_req.lim    = bs_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            end
            S_OUT:    o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_x[0] <= i_req.sample0;
                    r_x[1] <= i_req.sample1;
                    r_x[2] <= i_req.sample2;
                    r_x[3] <= i_req.sample3;
                    r_x[4] <= i_req.sample4;
                    r_x[5] <= i_req.sample5;
                    r_x[6] <= i_req.sample6;
                    r_x[7] <= i_req.sample7;
                    r_d    <= i_req.desired;
                    r_last <= i_req.last_row;
                    r_cnt  <= '0;
                end
            end
            S_ACC: begin
                r_cnt  <= r_cnt + 4'd1;
                r_n    <= n_taps;
                r_k    <= '0;
                r_r    <= '0;
                r_sing <= 1'b0;
                r_bs   <= 1'b0;
            end
            S_PV_CMP: begin
                if (r_r == r_k || mag48(rowdata[r_k]) > r_pmag) begin
                    r_pmag <= mag48(rowdata[r_k]);
                    r_p    <= r_r[2:0];
                end
                if (r_r != r_n - 4'd1) r_r <= r_r + 4'd1;
            end
            S_PV_CHK: begin
                if (r_pmag == '0) begin
                    r_sing <= 1'b1;
                    r_c    <= '0;
                end
            end
            S_SW_RDK: r_krow <= rowdata;
            S_SW_WRK: r_r <= r_k + 4'd1;
            S_EL_RD: begin
                if (r_r == r_n) begin
                    if (r_k == r_n - 4'd1) begin
                        r_bs <= 1'b1;
                    end else begin
                        r_k <= r_k + 4'd1;
                        r_r <= r_k + 4'd1;
                    end
                end
            end
            S_EL_LD: begin
                r_wrow <= rowdata;
                if (rowdata[r_k] == '0) begin
                    r_r <= r_r + 4'd1;
                end else begin
                    r_fneg <= rowdata[r_k][47] ^ r_krow[r_k][47];
                    r_c    <= (r_k + 4'd1 == r_n) ? B_COL : r_k + 4'd1;
                end
            end
            S_EL_DIV: if (div_rsp.done) r_f <= div_rsp.quot[31:0];
            S_EL_COL: begin
                r_mx    <= r_f;
                r_my    <= mag48(r_krow[r_c]);
                r_mneg  <= r_fneg ^ r_krow[r_c][47];
                r_msh16 <= 1'b0;
            end
            S_EL_WR:  r_r <= r_r + 4'd1;
            S_MUL0:   r_prod <= {16'd0, mul_p};
            S_MUL1:   r_prod <= r_prod + {mul_p, 16'd0};
            S_MUL_UPD: begin
                if (r_bs) begin
                    r_s <= upd_s;
                    if (r_c + 4'd1 != r_n) r_c <= r_c + 4'd1;
                end else begin
                    r_wrow[r_c] <= upd_a;
                    if (r_c != B_COL) r_c <= (r_c + 4'd1 == r_n) ? B_COL : r_c + 4'd1;
                end
            end
            S_BS_LD: begin
                r_wrow <= rowdata;
                r_s    <= 64'($signed(rowdata[B_COL]));
                r_c    <= r_k + 4'd1;
            end
            S_BS_COL: begin
                r_mx    <= mag32(r_w[r_c[2:0]]);
                r_my    <= mag48(r_wrow[r_c]);
                r_mneg  <= r_wrow[r_c][47] ^ r_w[r_c[2:0]][31];
                r_msh16 <= 1'b1;
            end
            S_BS_DIV: r_bneg <= bs_neg;
            S_BS_WAIT: begin
                if (div_rsp.done) begin
                    r_w[r_k[2:0]] <= wval;
                    if (r_k != 4'd0) r_k <= r_k - 4'd1;
                    else r_c <= '0;
                end
            end
            S_OUT:    r_c <= r_c + 4'd1;
            default: ;
        endcase
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not taken");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.singular |-> o_res.weight == 32'sd0) else $error("singular weight");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last_weight |=> !busy && !o_valid) else $error("run did not end");

    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last_weight |=>
            o_valid && o_res.weight_index == $past(o_res.weight_index) + 3'd1)
        else $error("weight order");

endmodule

### sv/wws_divider.sv
// Restoring fractional divider, one quotient bit per cycle, saturating.
module wws_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wws_pkg::t_div_req i_req,
    output wws_pkg::t_div_rsp o_rsp
);
    import wws_pkg::*;

    logic        r_run;
    logic [6:0]  r_cnt;
    logic [6:0]  r_last_cnt;
    logic [93:0] r_dvd;
    logic [47:0] r_den;
    logic [47:0] r_rem;
    logic [32:0] r_q;
    logic        r_ovf;
    logic [32:0] r_lim;
    logic        r_done;
    logic [32:0] r_quot;

    logic [48:0] trial;
    logic        ge;
    logic [48:0] diff;
    logic [32:0] q_nxt;
    logic        ovf_nxt;

    always_comb begin
        trial   = {r_rem, r_dvd[93]};
        ge      = trial >= {1'b0, r_den};
        diff    = trial - {1'b0, r_den};
        q_nxt   = {r_q[31:0], ge};
        ovf_nxt = r_ovf | r_q[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == r_last_cnt) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd      <= {i_req.num, 30'b0};
            r_den      <= i_req.den;
            r_rem      <= '0;
            r_q        <= '0;
            r_ovf      <= 1'b0;
            r_cnt      <= '0;
            r_last_cnt <= i_req.frac16 ? 7'd79 : 7'd93;
            r_lim      <= i_req.lim;
        end else if (r_run) begin
            r_dvd <= {r_dvd[92:0], 1'b0};
            r_rem <= ge ? diff[47:0] : trial[47:0];
            r_q   <= q_nxt;
            r_ovf <= ovf_nxt;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == r_last_cnt) begin
                r_quot <= (ovf_nxt || q_nxt > r_lim) ? r_lim : q_nxt;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### sim/tb.sv
// Testbench for wiener_weight_solver_top: directed and random batches of rows checked against a solver model.
`timescale 1ns / 1ps

module tb;
    import wws_pkg::*;

    localparam longint ACC_MAX = 64'sh00007FFFFFFFFFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint I64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint I64_MIN = 64'sh8000000000000000;
    localparam logic [2:0] ADDR_TAPS = 3'd0;
    localparam logic [2:0] ADDR_NONE = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_request    i_req;
    logic        o_valid;
    t_result     o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wiener_weight_solver_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_request rows_due[$];
    t_result  weights_due[$];
    longint   corr_sum[8][8];
    longint   cross_sum[8];
    logic [3:0] taps_reg;
    int       errors;
    int       rows_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clip(logic signed [65:0] v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v[63:0];
    endfunction

    function automatic longint sadd(longint a, longint b, longint lo, longint hi);
        logic signed [65:0] s;
        s = a;
        s = s + b;
        return clip(s, lo, hi);
    endfunction

    function automatic logic [63:0] umag(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint ssat(logic [63:0] m, bit neg, longint lo, longint hi);
        if (neg) begin
            if (m >= umag(lo)) return lo;
            return -longint'(m);
        end
        if (m >= 64'(hi)) return hi;
        return longint'(m);
    endfunction

    function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int s,
                                          logic [63:0] lim);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> s;
        return p > {64'b0, lim} ? lim : p[63:0];
    endfunction

    function automatic logic [63:0] divfr(logic [63:0] n, logic [63:0] d, int fb,
                                          logic [63:0] lim);
        logic [127:0] q;
        if (n / d > (lim >> fb)) return lim;
        q = ({64'b0, n} << fb) / {64'b0, d};
        return q > {64'b0, lim} ? lim : q[63:0];
    endfunction

    task automatic solve_row(t_request r);
        longint x[8];
        longint a[8][8];
        longint b[8];
        longint w[8];
        longint dv, t, pv, s;
        logic [63:0] fm, pm, q;
        bit sing, fneg, neg;
        int n, p;
        t_result e;
        x[0] = r.sample0; x[1] = r.sample1; x[2] = r.sample2; x[3] = r.sample3;
        x[4] = r.sample4; x[5] = r.sample5; x[6] = r.sample6; x[7] = r.sample7;
        dv = r.desired;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++)
                corr_sum[i][j] = sadd(corr_sum[i][j], x[i] * x[j], ACC_MIN, ACC_MAX);
            cross_sum[i] = sadd(cross_sum[i], x[i] * dv, ACC_MIN, ACC_MAX);
        end
        if (!r.last_row) return;
        n = taps_reg;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                a[i][j] = corr_sum[i][j];
                corr_sum[i][j] = 0;
            end
            b[i] = cross_sum[i];
            cross_sum[i] = 0;
            w[i] = 0;
        end
        sing = 1'b0;
        for (int k = 0; k < n && !sing; k++) begin
            p = k;
            for (int rr = k + 1; rr < n; rr++)
                if (umag(a[rr][k]) > umag(a[p][k])) p = rr;
            if (a[p][k] == 0) begin
                sing = 1'b1;
            end else begin
                if (p != k) begin
                    for (int c = 0; c < n; c++) begin
                        t = a[k][c]; a[k][c] = a[p][c]; a[p][c] = t;
                    end
                    t = b[k]; b[k] = b[p]; b[p] = t;
                end
                for (int rr = k + 1; rr < n; rr++) begin
                    if (a[rr][k] != 0) begin
                        fm = divfr(umag(a[rr][k]), umag(a[k][k]), 30, 64'd1 << 30);
                        fneg = (a[rr][k] < 0) != (a[k][k] < 0);
                        for (int c = k + 1; c < n; c++) begin
                            pm = mulsh(fm, umag(a[k][c]), 30, 64'd1 << 62);
                            pv = ssat(pm, fneg != (a[k][c] < 0), I64_MIN, I64_MAX);
                            a[rr][c] = sadd(a[rr][c], -pv, ACC_MIN, ACC_MAX);
                        end
                        pm = mulsh(fm, umag(b[k]), 30, 64'd1 << 62);
                        pv = ssat(pm, fneg != (b[k] < 0), I64_MIN, I64_MAX);
                        b[rr] = sadd(b[rr], -pv, ACC_MIN, ACC_MAX);
                        a[rr][k] = 0;
                    end
                end
            end
        end
        if (!sing) begin
            for (int k = n - 1; k >= 0; k--) begin
                s = b[k];
                for (int c = k + 1; c < n; c++) begin
                    pm = mulsh(umag(a[k][c]), umag(w[c]), 16, 64'd1 << 62);
                    pv = ssat(pm, (a[k][c] < 0) != (w[c] < 0), I64_MIN, I64_MAX);
                    s = sadd(s, -pv, I64_MIN, I64_MAX);
                end
                neg = (s < 0) != (a[k][k] < 0);
                q = divfr(umag(s), umag(a[k][k]), 16,
                          neg ? 64'h80000000 : 64'h7FFFFFFF);
                w[k] = ssat(q, neg, -64'sh80000000, 64'sh7FFFFFFF);
            end
        end
        for (int k = 0; k < n; k++) begin
            e.weight_index = 3'(k);
            e.weight = sing ? 32'sd0 : w[k][31:0];
            e.singular = sing;
            e.last_weight = (k == n - 1);
            weights_due.push_back(e);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive
        bit took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                solve_row(i_req);
                void'(rows_due.pop_front());
                rows_sent++;
            end
            if (start && !took) begin
                start <= 1'b1;
            end else if (rows_due.size() > 0 &&
                         ((rows_sent >= 50 && rows_sent < 80) || $urandom_range(99) >= 31)) begin
                start <= 1'b1;
                i_req <= rows_due[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_result e;
        if (i_rst_n && o_valid) begin
            if (weights_due.size() == 0) begin
                $display("%0t: unexpected weight idx=%0d w=%0d sing=%0b last=%0b", $time,
                         o_res.weight_index, o_res.weight, o_res.singular, o_res.last_weight);
                errors++;
            end else begin
                e = weights_due.pop_front();
                if (o_res.weight_index !== e.weight_index) begin
                    $display("%0t: weight_index exp %0d got %0d", $time,
                             e.weight_index, o_res.weight_index);
                    errors++;
                end
                if (o_res.weight !== e.weight) begin
                    $display("%0t: weight[%0d] exp %0d got %0d", $time,
                             e.weight_index, e.weight, o_res.weight);
                    errors++;
                end
                if (o_res.singular !== e.singular) begin
                    $display("%0t: singular exp %0b got %0b", $time, e.singular, o_res.singular);
                    errors++;
                end
                if (o_res.last_weight !== e.last_weight) begin
                    $display("%0t: last_weight exp %0b got %0b", $time,
                             e.last_weight, o_res.last_weight);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        @(posedge i_clk);
        while (rows_due.size() > 0 || start || busy || weights_due.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_TAPS) taps_reg = data[3:0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(512) - 256);
            default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function automatic t_request rand_row(bit last);
        t_request r;
        int mode;
        mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
        r.sample0 = rand_sample(mode); r.sample1 = rand_sample(mode);
        r.sample2 = rand_sample(mode); r.sample3 = rand_sample(mode);
        r.sample4 = rand_sample(mode); r.sample5 = rand_sample(mode);
        r.sample6 = rand_sample(mode); r.sample7 = rand_sample(mode);
        r.desired = rand_sample(mode);
        r.last_row = last;
        return r;
    endfunction

    function automatic t_request fill_row(logic [15:0] v, logic [15:0] d, bit last);
        t_request r;
        r = {v, v, v, v, v, v, v, v, d, last};
        return r;
    endfunction

    task automatic push_batches(int count);
        int len;
        while (count > 0) begin
            len = $urandom_range(9) < 8 ? $urandom_range(10, 4) : $urandom_range(3, 1);
            if (len > count) len = count;
            for (int i = 0; i < len; i++) rows_due.push_back(rand_row(i == len - 1));
            count -= len;
        end
    endtask

    initial begin : stim
        t_request r;
        logic [3:0] taps_plan[7];
        errors = 0;
        rows_sent = 0;
        taps_reg = 4'd8;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < 8; i++) begin
            cross_sum[i] = 0;
            for (int j = 0; j < 8; j++) corr_sum[i][j] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, all-zero batch, diagonal batch, batch of -1 samples
        rows_due.push_back(fill_row(16'h7FFF, 16'h8000, 1'b0));
        rows_due.push_back(fill_row(16'h8000, 16'h7FFF, 1'b1));
        rows_due.push_back(fill_row(16'h0000, 16'h0000, 1'b1));
        for (int k = 0; k < 8; k++) begin
            r = fill_row(16'h0000, 16'(k * 4000 - 16000), k == 7);
            r[17 + 16 * (7 - k) +: 16] = 16'h4000;
            rows_due.push_back(r);
        end
        rows_due.push_back(fill_row(16'hFFFF, 16'h0001, 1'b1));
        wait_drained();
        reg_write(ADDR_TAPS, 32'd1);
        rows_due.push_back(fill_row(16'h7FFF, 16'h7FFF, 1'b1));
        rows_due.push_back(fill_row(16'h0000, 16'h1234, 1'b1));
        wait_drained();
        reg_write(ADDR_TAPS, 32'd0);
        rows_due.push_back(fill_row(16'h8000, 16'h8000, 1'b1));
        wait_drained();
        reg_write(ADDR_TAPS, 32'hFFFF_FFFF);
        rows_due.push_back(rand_row(1'b0));
        rows_due.push_back(rand_row(1'b1));
        wait_drained();
        reg_write(ADDR_TAPS, 32'd8);
        reg_write(ADDR_NONE, 32'd3);
        rows_due.push_back(rand_row(1'b1));

        taps_plan = '{4'd8, 4'd3, 4'd1, 4'd8, 4'd5, 4'd2, 4'd8};
        foreach (taps_plan[i]) begin
            wait_drained();
            reg_write(ADDR_TAPS, {28'd0, taps_plan[i]});
            push_batches(i == 3 ? 24 : 13);
        end
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
